### rtl/core/sogi_quadrature_filter_macros.svh
// ----------------------------------------------------------------------------
// SOGI quadrature filter assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SOGI_QUADRATURE_FILTER_MACROS_SVH
`define SOGI_QUADRATURE_FILTER_MACROS_SVH

// Same-cycle implication
`define SQF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SQF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sqf_pkg.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter package
// Register index codes and fixed widths shared by the filter files.
// ----------------------------------------------------------------------------
package sqf_pkg;

  // Width of the register index on the configuration channel
  localparam int CfgIndexWidth = 8;

  // Coefficient register map
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_FEEDBACK_A1  = 8'd0,
    CFG_FEEDBACK_A2  = 8'd1,
    CFG_INPHASE_GAIN = 8'd2,
    CFG_QUAD_GAIN    = 8'd3
  } cfg_reg_e;

endpackage

### rtl/core/sqf_if.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter channel interfaces
// Valid/ready channels for samples, results and coefficient writes.
// ----------------------------------------------------------------------------

// Sample channel: one signed sample per item
interface sqf_sample_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: in-phase, quadrature and error per item
interface sqf_result_if #(
  parameter int STATE_WIDTH = 18
) ();
  logic                          valid;
  logic                          ready;
  logic signed [STATE_WIDTH-1:0] in_phase;
  logic signed [STATE_WIDTH-1:0] quadrature;
  logic signed [STATE_WIDTH-1:0] error;

  modport source (output valid, output in_phase, output quadrature, output error,
                  input ready);
  modport sink   (input valid, input in_phase, input quadrature, input error,
                  output ready);
endinterface

// Coefficient write channel
interface sqf_cfg_if #(
  parameter int COEF_WIDTH = 32
) ();
  logic                               valid;
  logic                               ready;
  logic [sqf_pkg::CfgIndexWidth-1:0]  index;
  logic [COEF_WIDTH-1:0]              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sogi_quadrature_filter.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter
// Channel    Dir  Payload                             Accepted when
// sample_i   in   sample                              valid & ready
// result_o   out  in_phase, quadrature, error         valid & ready
// cfg_i      in   index, data (coefficient write)     valid & ready (ready is 1)
//
// One item per cycle sustained while result_o is ready; an accepted item is
// held in the sample register, then in the result register. The rate is set
// by the history feedback: both biquads and their six multipliers sit
// between the sample register and the result register. Reset clears the
// coefficients, delay line, history and both valid flags. A stalled result
// holds in its register while the sample register takes one more item.
// ----------------------------------------------------------------------------
module sogi_quadrature_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 18,
  parameter int COEF_WIDTH   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sqf_cfg_if.sink       cfg_i,
  sqf_sample_if.sink    sample_i,
  sqf_result_if.source  result_o
);

`include "sogi_quadrature_filter_macros.svh"

  localparam int IpTapWidth = SAMPLE_WIDTH + 1;
  localparam int QdTapWidth = SAMPLE_WIDTH + 2;
  localparam int ErrWidth   = ((SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH) + 1;

  logic signed [COEF_WIDTH-1:0]   fb_a1, fb_a2, inphase_gain, quad_gain;
  logic                           in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q;
  logic signed [STATE_WIDTH-1:0]  y1_q, y2_q, q1_q, q2_q;
  logic                           out_valid_q;
  logic signed [STATE_WIDTH-1:0]  in_phase_q, quadrature_q, error_q;
  logic                           fire;
  logic signed [IpTapWidth-1:0]   ip_taps;
  logic signed [QdTapWidth-1:0]   qd_taps;
  logic signed [STATE_WIDTH-1:0]  y0, q0, err;
  logic signed [ErrWidth-1:0]     err_diff;

  sqf_cfg_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .fb_a1_o        (fb_a1),
    .fb_a2_o        (fb_a2),
    .inphase_gain_o (inphase_gain),
    .quad_gain_o    (quad_gain)
  );

  // Move the held item into the result register when that register frees up
  assign fire           = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || fire;

  // Capture incoming samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      sample_q <= sample_i.sample;
    end
  end

  // Numerator tap sums
  assign ip_taps = IpTapWidth'(sample_q) - IpTapWidth'(x2_q);
  assign qd_taps = QdTapWidth'(sample_q) + (QdTapWidth'(x1_q) <<< 1) + QdTapWidth'(x2_q);

  sqf_biquad #(
    .TAP_WIDTH   (IpTapWidth),
    .STATE_WIDTH (STATE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_inphase (
    .tap_sum_i  (ip_taps),
    .num_coef_i (inphase_gain),
    .fb_a1_i    (fb_a1),
    .fb_a2_i    (fb_a2),
    .hist1_i    (y1_q),
    .hist2_i    (y2_q),
    .out_o      (y0)
  );

  sqf_biquad #(
    .TAP_WIDTH   (QdTapWidth),
    .STATE_WIDTH (STATE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_quad (
    .tap_sum_i  (qd_taps),
    .num_coef_i (quad_gain),
    .fb_a1_i    (fb_a1),
    .fb_a2_i    (fb_a2),
    .hist1_i    (q1_q),
    .hist2_i    (q2_q),
    .out_o      (q0)
  );

  // Error against the saturated in-phase value
  assign err_diff = ErrWidth'(sample_q) - ErrWidth'(y0);

  sqf_saturate #(
    .IN_WIDTH  (ErrWidth),
    .OUT_WIDTH (STATE_WIDTH)
  ) u_err_sat (
    .value_i (err_diff),
    .value_o (err)
  );

  // Advance the delay line and output history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      q1_q <= '0;
      q2_q <= '0;
    end else if (fire) begin
      x1_q <= sample_q;
      x2_q <= x1_q;
      y1_q <= y0;
      y2_q <= y1_q;
      q1_q <= q0;
      q2_q <= q1_q;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      in_phase_q   <= y0;
      quadrature_q <= q0;
      error_q      <= err;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.in_phase   = in_phase_q;
  assign result_o.quadrature = quadrature_q;
  assign result_o.error      = error_q;

  // Checks
  `SQF_ASSERT_NEXT(a_hist_tracks_result, clk_i, rst_ni, fire, (y1_q == in_phase_q) && (q1_q == quadrature_q), "history differs from issued result")
  `SQF_ASSERT_NEXT(a_hist_holds, clk_i, rst_ni, !fire, $stable(y1_q) && $stable(q1_q) && $stable(x1_q), "history moved without an item")
  `SQF_ASSERT_NEXT(a_item_kept, clk_i, rst_ni, in_valid_q && !fire, in_valid_q && $stable(sample_q), "held sample lost")
  `SQF_ASSERT_NEXT(a_result_flagged, clk_i, rst_ni, fire, out_valid_q, "result register not flagged after transfer")

endmodule

### rtl/core/sqf_saturate.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter saturator
// Clamps a signed value to a narrower signed range.
// ----------------------------------------------------------------------------
module sqf_saturate #(
  parameter int IN_WIDTH  = 24,
  parameter int OUT_WIDTH = 18
) (
  input  logic signed [IN_WIDTH-1:0]  value_i,
  output logic signed [OUT_WIDTH-1:0] value_o
);

  localparam logic signed [OUT_WIDTH-1:0] MaxVal = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_WIDTH-1:0] MinVal = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  logic [IN_WIDTH-OUT_WIDTH:0] upper;
  logic                        overflow;

  // Overflow when the bits above the kept sign are not all copies of it
  assign upper    = value_i[IN_WIDTH-1:OUT_WIDTH-1];
  assign overflow = !((&upper) || !(|upper));

  always_comb begin
    if (overflow) begin
      value_o = value_i[IN_WIDTH-1] ? MinVal : MaxVal;
    end else begin
      value_o = value_i[OUT_WIDTH-1:0];
    end
  end

endmodule

### rtl/core/sqf_biquad.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter biquad section
// One Tustin section: numerator gain on a tap sum, minus the shared
// denominator on two past outputs, rounded half up and saturated.
// ----------------------------------------------------------------------------
module sqf_biquad #(
  parameter int TAP_WIDTH   = 17,
  parameter int STATE_WIDTH = 18,
  parameter int COEF_WIDTH  = 32
) (
  input  logic signed [TAP_WIDTH-1:0]   tap_sum_i,
  input  logic signed [COEF_WIDTH-1:0]  num_coef_i,
  input  logic signed [COEF_WIDTH-1:0]  fb_a1_i,
  input  logic signed [COEF_WIDTH-1:0]  fb_a2_i,
  input  logic signed [STATE_WIDTH-1:0] hist1_i,
  input  logic signed [STATE_WIDTH-1:0] hist2_i,
  output logic signed [STATE_WIDTH-1:0] out_o
);

  localparam int MaxOpWidth = (TAP_WIDTH > STATE_WIDTH) ? TAP_WIDTH : STATE_WIDTH;
  localparam int ProdWidth  = COEF_WIDTH + MaxOpWidth;
  localparam int AccWidth   = ProdWidth + 2;
  localparam int FracBits   = COEF_WIDTH - 3;
  localparam int RndWidth   = AccWidth - FracBits;
  localparam logic signed [AccWidth-1:0] Half = AccWidth'(1) << (FracBits - 1);

  logic signed [ProdWidth-1:0] num_prod;
  logic signed [ProdWidth-1:0] fb1_prod;
  logic signed [ProdWidth-1:0] fb2_prod;
  logic signed [AccWidth-1:0]  acc;
  logic signed [RndWidth-1:0]  rnd;

  // Three independent products, exact at full width
  assign num_prod = num_coef_i * tap_sum_i;
  assign fb1_prod = fb_a1_i * hist1_i;
  assign fb2_prod = fb_a2_i * hist2_i;

  // Sum with the rounding half folded in, then drop the fraction (floor)
  assign acc = AccWidth'(num_prod) - AccWidth'(fb1_prod) - AccWidth'(fb2_prod) + Half;
  assign rnd = acc[AccWidth-1:FracBits];

  sqf_saturate #(
    .IN_WIDTH  (RndWidth),
    .OUT_WIDTH (STATE_WIDTH)
  ) u_sat (
    .value_i (rnd),
    .value_o (out_o)
  );

endmodule

### rtl/core/sqf_cfg_regs.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter coefficient registers
// Holds the four Q2 coefficients written over the configuration channel.
// ----------------------------------------------------------------------------
module sqf_cfg_regs #(
  parameter int COEF_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sqf_cfg_if.sink                      cfg_i,
  output logic signed [COEF_WIDTH-1:0] fb_a1_o,
  output logic signed [COEF_WIDTH-1:0] fb_a2_o,
  output logic signed [COEF_WIDTH-1:0] inphase_gain_o,
  output logic signed [COEF_WIDTH-1:0] quad_gain_o
);

  logic signed [COEF_WIDTH-1:0] fb_a1_q, fb_a2_q, inphase_gain_q, quad_gain_q;

  // Writes never stall
  assign cfg_i.ready = 1'b1;

  // Store the addressed coefficient; drop writes to unmapped indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_a1_q        <= '0;
      fb_a2_q        <= '0;
      inphase_gain_q <= '0;
      quad_gain_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sqf_pkg::CFG_FEEDBACK_A1:  fb_a1_q        <= cfg_i.data;
        sqf_pkg::CFG_FEEDBACK_A2:  fb_a2_q        <= cfg_i.data;
        sqf_pkg::CFG_INPHASE_GAIN: inphase_gain_q <= cfg_i.data;
        sqf_pkg::CFG_QUAD_GAIN:    quad_gain_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign fb_a1_o        = fb_a1_q;
  assign fb_a2_o        = fb_a2_q;
  assign inphase_gain_o = inphase_gain_q;
  assign quad_gain_o    = quad_gain_q;

endmodule
